// ----- hw/rtl/sef_pkg.sv -----
// Shared constants, register codes and sequencer states for the stereo envelope follower.
// Depends on nothing; the interfaces, the top level and the test files use it by scoped names.
package sef_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int COEFF_BITS    = 24;
   localparam int ENV_FRAC_BITS = 16;
   localparam int LINK_BITS     = 16;
   localparam int GR_BITS       = 16;

   // auto-release reaches the fast value at 12 dB = 3 << 10 in Q8.8
   localparam int GR_SHIFT = 10;
   localparam int GR_DIV   = 3;
   localparam int GR_FULL  = GR_DIV << GR_SHIFT;
   localparam int GR_HALF  = GR_FULL / 2;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DETECTION_MODE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AUTO_RELEASE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_COEFF       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_COEFF      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_FAST_COEFF = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_SLOW_COEFF = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RMS_COEFF          = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINK_AMOUNT        = 3'd7;

   localparam int ATTACK_RESET       = 34914;
   localparam int RELEASE_RESET      = 3495;
   localparam int RELEASE_FAST_RESET = 6989;
   localparam int RELEASE_SLOW_RESET = 175;
   localparam int RMS_RESET          = 34914;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_MS,
      ST_ROOT,
      ST_LINK,
      ST_REL_MUL,
      ST_REL_DIV,
      ST_ENV,
      ST_DONE
   } sef_state_type;

endpackage

// ----- hw/rtl/sef_req_if.sv -----
// Input channel interface of the stereo envelope follower.
// Depends on sef_pkg for default widths.
interface sef_req_if #(
   parameter int SAMPLE_BITS = sef_pkg::SAMPLE_BITS
);
   logic                               valid;
   logic                               ready;
   logic signed [SAMPLE_BITS-1:0]      sample_left;
   logic signed [SAMPLE_BITS-1:0]      sample_right;
   logic [sef_pkg::GR_BITS-1:0]        gain_reduction_db;

   modport source (output valid, sample_left, sample_right, gain_reduction_db, input ready);
   modport sink (input valid, sample_left, sample_right, gain_reduction_db, output ready);
endinterface

// ----- hw/rtl/sef_rsp_if.sv -----
// Result channel interface of the stereo envelope follower.
// Depends on sef_pkg for default widths.
interface sef_rsp_if #(
   parameter int SAMPLE_BITS = sef_pkg::SAMPLE_BITS
);
   localparam int OUT_W = SAMPLE_BITS - 1;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] envelope_left;
   logic [OUT_W-1:0] envelope_right;

   modport source (output valid, envelope_left, envelope_right, input ready);
   modport sink (input valid, envelope_left, envelope_right, output ready);
endinterface

// ----- hw/rtl/sef_mul.sv -----
// Bit-serial shift-add multiplier: one multiplier bit per cycle over the B_W-bit multiplier.
// Standalone; used by the stereo envelope follower sequencer.
module sef_mul #(
   parameter int A_W = 48,
   parameter int B_W = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] prod
);
   localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [A_W-1:0]   acc_ff, acc_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [A_W:0]     sum;

   assign sum = {1'b0, acc_ff} + (b_ff[0] ? {1'b0, a_ff} : {(A_W+1){1'b0}});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         lo_in   = '0;
      end else if (busy_ff) begin
         // product low bits leave the accumulator into lo, LSB first
         acc_in = sum[A_W:1];
         lo_in  = {sum[0], lo_ff[B_W-1:1]};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign done = done_ff;
   assign prod = {acc_ff, lo_ff};
endmodule

// ----- hw/rtl/sef_isqrt.sv -----
// Digit-by-digit integer square root, one result bit per cycle.
// Standalone; used by the stereo envelope follower for RMS detection.
module sef_isqrt #(
   parameter int V_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [V_W-1:0]   value,
   output logic             done,
   output logic [V_W/2-1:0] root
);
   localparam int R_W   = V_W / 2;
   localparam int T_W   = R_W + 3;
   localparam int CNT_W = (R_W > 1) ? $clog2(R_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [V_W-1:0]   v_ff, v_in;
   logic [R_W:0]     rem_ff, rem_in;
   logic [R_W-1:0]   root_ff, root_in;
   logic [T_W-1:0]   rem2, trial, rem_sub;
   logic             ge;

   assign rem2    = {rem_ff, v_ff[V_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = rem2 >= trial;
   assign rem_sub = rem2 - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         v_in    = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         v_in    = v_ff << 2;
         rem_in  = ge ? rem_sub[R_W:0] : rem2[R_W:0];
         root_in = {root_ff[R_W-2:0], ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(R_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ----- hw/rtl/stereo_envelope_follower.sv -----
// Stereo envelope follower: sequencer, state and config registers around serial units.
// Depends on sef_pkg, sef_req_if, sef_rsp_if, sef_mul and sef_isqrt.
//
// Usage: req_ch carries one stereo sample pair plus the gain reduction per word;
// rsp_ch returns both envelopes, one word per request word, in order.
// Registers are written through csr_we / csr_index / csr_wdata while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// req_ch.ready is high only while the sequencer is idle; one pair is worked at a time.
// All multiplications share one bit-serial multiplier, one multiplier bit per cycle, its
// multiplier width being 25 by default; square roots run on a separate serial unit.
// Per pair, peak mode runs a link and an envelope step for each channel; auto-release
// interpolation adds a multiply and a serial divide by 3, and RMS mode adds two squares,
// two mean-square updates and two square roots.
// The result sits in an output register; the next pair is accepted while it waits.
// If the receiver stalls, a finished second pair waits in the sequencer until the
// output register frees up.
// Reset clears envelopes, mean squares and the output valid, and loads the
// register defaults.
module stereo_envelope_follower #(
   parameter int SAMPLE_BITS   = sef_pkg::SAMPLE_BITS,
   parameter int COEFF_BITS    = sef_pkg::COEFF_BITS,
   parameter int ENV_FRAC_BITS = sef_pkg::ENV_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   sef_req_if.sink                             req_ch,
   sef_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [sef_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [COEFF_BITS:0]                 csr_wdata
);
   localparam int SB    = SAMPLE_BITS;
   localparam int CB    = COEFF_BITS;
   localparam int FB    = ENV_FRAC_BITS;
   localparam int LB    = sef_pkg::LINK_BITS;
   localparam int GB    = sef_pkg::GR_BITS;
   localparam int CW    = CB + 1;
   localparam int LW    = LB + 1;
   localparam int MS_W  = 2 * SB;
   localparam int ENV_W = SB + FB;
   localparam int OUT_W = SB - 1;
   localparam int MA_0  = (MS_W > ENV_W) ? MS_W : ENV_W;
   localparam int MA_W  = (MA_0 > CW) ? MA_0 : CW;
   localparam int MB_0  = (CW > SB) ? CW : SB;
   localparam int MB_W  = (MB_0 > GB) ? MB_0 : GB;
   localparam int PW    = MA_W + MB_W;
   localparam int Y_W   = CW + 2;
   localparam int DC_W  = $clog2(Y_W);

   localparam logic [CW-1:0] UNITY      = {1'b1, {CB{1'b0}}};
   localparam logic [LW-1:0] LINK_UNITY = {1'b1, {LB{1'b0}}};

   sef_pkg::sef_state_type state_ff, state_in;
   logic                   ch_ff, ch_in;
   logic                   launch_ff, launch_in;

   logic            mode_ff, mode_in;
   logic            auto_ff, auto_in;
   logic [CW-1:0]   attack_ff, attack_in;
   logic [CW-1:0]   release_ff, release_in;
   logic [CW-1:0]   fast_ff, fast_in;
   logic [CW-1:0]   slow_ff, slow_in;
   logic [CW-1:0]   rms_ff, rms_in;
   logic [LW-1:0]   link_ff, link_in;

   logic [SB-1:0]    mag_ff [2];
   logic [SB-1:0]    mag_in [2];
   logic [GB-1:0]    gr_ff, gr_in;
   logic [MS_W-1:0]  sq_ff, sq_in;
   logic [MS_W-1:0]  ms_ff [2];
   logic [MS_W-1:0]  ms_in [2];
   logic [ENV_W-1:0] tgt_ff [2];
   logic [ENV_W-1:0] tgt_in [2];
   logic [ENV_W-1:0] env_ff [2];
   logic [ENV_W-1:0] env_in [2];
   logic [ENV_W-1:0] peak_ff, peak_in;
   logic [CW-1:0]    rel_ff, rel_in;
   logic [Y_W-1:0]   dv_ff, dv_in;
   logic [1:0]       rm_ff, rm_in;
   logic [DC_W-1:0]  dcnt_ff, dcnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] out_ff [2];
   logic [OUT_W-1:0] out_in [2];

   // serial units
   logic            mul_start, mul_done;
   logic [MA_W-1:0] mul_a;
   logic [MB_W-1:0] mul_b;
   logic [PW-1:0]   mul_prod;
   logic            sqrt_start, sqrt_done;
   logic [SB-1:0]   sqrt_root;

   sef_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   sef_isqrt #(.V_W(MS_W)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (ms_ff[ch_ff]),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // clamped coefficients
   logic [CW-1:0] attack_c, release_c, fast_c, slow_c, rms_c;
   logic [LW-1:0] link_c;

   assign attack_c  = (attack_ff > UNITY) ? UNITY : attack_ff;
   assign release_c = (release_ff > UNITY) ? UNITY : release_ff;
   assign fast_c    = (fast_ff > UNITY) ? UNITY : fast_ff;
   assign slow_c    = (slow_ff > UNITY) ? UNITY : slow_ff;
   assign rms_c     = (rms_ff > UNITY) ? UNITY : rms_ff;
   assign link_c    = (link_ff > LINK_UNITY) ? LINK_UNITY : link_ff;

   // magnitudes of the incoming pair; the most negative code maps to 2^(SB-1)
   logic [SB-1:0] mag_new_l, mag_new_r;

   assign mag_new_l = req_ch.sample_left[SB-1]  ? (~$unsigned(req_ch.sample_left) + SB'(1))
                                                : $unsigned(req_ch.sample_left);
   assign mag_new_r = req_ch.sample_right[SB-1] ? (~$unsigned(req_ch.sample_right) + SB'(1))
                                                : $unsigned(req_ch.sample_right);

   // per-step operands
   logic [MS_W-1:0]  cur_ms, ms_diff;
   logic             ms_up;
   logic [ENV_W-1:0] cur_tgt, cur_env, env_diff, peak_now, link_peak, link_diff;
   logic             env_up, env_rise;
   logic [CW-1:0]    env_c, rel_diff;
   logic             rel_up, gr_full;

   assign cur_ms    = ms_ff[ch_ff];
   assign ms_up     = sq_ff >= cur_ms;
   assign ms_diff   = ms_up ? (sq_ff - cur_ms) : (cur_ms - sq_ff);
   assign cur_tgt   = tgt_ff[ch_ff];
   assign cur_env   = env_ff[ch_ff];
   assign env_up    = cur_tgt >= cur_env;
   assign env_rise  = cur_tgt > cur_env;
   assign env_diff  = env_up ? (cur_tgt - cur_env) : (cur_env - cur_tgt);
   assign env_c     = env_rise ? attack_c : rel_ff;
   assign peak_now  = (tgt_ff[0] > tgt_ff[1]) ? tgt_ff[0] : tgt_ff[1];
   // left target moves during its link step, so the right one uses the held peak
   assign link_peak = ch_ff ? peak_ff : peak_now;
   assign link_diff = link_peak - cur_tgt;
   assign rel_up    = fast_c >= slow_c;
   assign rel_diff  = rel_up ? (fast_c - slow_c) : (slow_c - fast_c);
   assign gr_full   = gr_ff >= GB'(sef_pkg::GR_FULL);

   // rounded step: (P >> s) + P[s-1], s = link or coefficient fraction bits
   logic            use_link;
   logic [MA_W-1:0] step_hi, step;
   logic            step_rb;

   assign step_hi = use_link ? mul_prod[LB +: MA_W] : mul_prod[CB +: MA_W];
   assign step_rb = use_link ? mul_prod[LB-1] : mul_prod[CB-1];
   assign step    = step_hi + MA_W'(step_rb);

   // auto-release blend: (d*gr + 1536) / 3072 as a shift and a serial divide by 3
   logic [PW:0]    y_sum;
   logic [2:0]     dv_t;
   logic           dv_ge;
   logic [1:0]     rm_next;
   logic [Y_W-1:0] q_next;
   logic           div_last;

   assign y_sum    = {1'b0, mul_prod} + (PW+1)'(sef_pkg::GR_HALF);
   assign dv_t     = {rm_ff, dv_ff[Y_W-1]};
   assign dv_ge    = dv_t >= 3'(sef_pkg::GR_DIV);
   assign rm_next  = dv_ge ? 2'(dv_t - 3'(sef_pkg::GR_DIV)) : dv_t[1:0];
   assign q_next   = {dv_ff[Y_W-2:0], dv_ge};
   assign div_last = dcnt_ff == DC_W'(Y_W - 1);

   // saturated outputs
   logic [SB-1:0]    env_sh [2];
   logic [OUT_W-1:0] env_sat [2];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         env_sh[i]  = env_ff[i][ENV_W-1:FB];
         env_sat[i] = env_sh[i][SB-1] ? {OUT_W{1'b1}} : env_sh[i][OUT_W-1:0];
      end
   end

   logic out_free, req_fire, out_load;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      case (state_ff)
         sef_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               ch_in    = 1'b0;
               state_in = mode_ff ? sef_pkg::ST_SQ : sef_pkg::ST_LINK;
            end
         end
         sef_pkg::ST_SQ: begin
            if (mul_done) state_in = sef_pkg::ST_MS;
         end
         sef_pkg::ST_MS: begin
            if (mul_done) state_in = sef_pkg::ST_ROOT;
         end
         sef_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               if (!ch_ff) begin
                  ch_in    = 1'b1;
                  state_in = sef_pkg::ST_SQ;
               end else begin
                  ch_in    = 1'b0;
                  state_in = sef_pkg::ST_LINK;
               end
            end
         end
         sef_pkg::ST_LINK: begin
            if (mul_done) begin
               if (!ch_ff) begin
                  ch_in = 1'b1;
               end else begin
                  ch_in    = 1'b0;
                  state_in = (auto_ff && !gr_full) ? sef_pkg::ST_REL_MUL : sef_pkg::ST_ENV;
               end
            end
         end
         sef_pkg::ST_REL_MUL: begin
            if (mul_done) state_in = sef_pkg::ST_REL_DIV;
         end
         sef_pkg::ST_REL_DIV: begin
            if (div_last) state_in = sef_pkg::ST_ENV;
         end
         sef_pkg::ST_ENV: begin
            if (mul_done) begin
               if (!ch_ff) begin
                  ch_in = 1'b1;
               end else begin
                  ch_in    = 1'b0;
                  state_in = sef_pkg::ST_DONE;
               end
            end
         end
         sef_pkg::ST_DONE: begin
            if (out_free) state_in = sef_pkg::ST_IDLE;
         end
         default: begin
            state_in = sef_pkg::ST_IDLE;
            ch_in    = 1'b0;
         end
      endcase
      launch_in = (state_in != state_ff) || (ch_in != ch_ff);
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      mul_start    = 1'b0;
      sqrt_start   = 1'b0;
      use_link     = 1'b0;
      out_load     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         sef_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         sef_pkg::ST_SQ: begin
            mul_start = launch_ff;
            mul_a     = MA_W'(mag_ff[ch_ff]);
            mul_b     = MB_W'(mag_ff[ch_ff]);
         end
         sef_pkg::ST_MS: begin
            mul_start = launch_ff;
            mul_a     = MA_W'(ms_diff);
            mul_b     = MB_W'(rms_c);
         end
         sef_pkg::ST_ROOT: begin
            sqrt_start = launch_ff;
         end
         sef_pkg::ST_LINK: begin
            mul_start = launch_ff;
            use_link  = 1'b1;
            mul_a     = MA_W'(link_diff);
            mul_b     = MB_W'(link_c);
         end
         sef_pkg::ST_REL_MUL: begin
            mul_start = launch_ff;
            mul_a     = MA_W'(rel_diff);
            mul_b     = MB_W'(gr_ff);
         end
         sef_pkg::ST_REL_DIV: begin
         end
         sef_pkg::ST_ENV: begin
            mul_start = launch_ff;
            mul_a     = MA_W'(env_diff);
            mul_b     = MB_W'(env_c);
         end
         sef_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // datapath and register file
   always_comb begin
      mode_in    = mode_ff;
      auto_in    = auto_ff;
      attack_in  = attack_ff;
      release_in = release_ff;
      fast_in    = fast_ff;
      slow_in    = slow_ff;
      rms_in     = rms_ff;
      link_in    = link_ff;
      mag_in     = mag_ff;
      gr_in      = gr_ff;
      sq_in      = sq_ff;
      ms_in      = ms_ff;
      tgt_in     = tgt_ff;
      env_in     = env_ff;
      peak_in    = peak_ff;
      rel_in     = rel_ff;
      dv_in      = dv_ff;
      rm_in      = rm_ff;
      dcnt_in    = dcnt_ff;
      out_in     = out_ff;

      if (req_fire) begin
         mag_in[0] = mag_new_l;
         mag_in[1] = mag_new_r;
         gr_in     = req_ch.gain_reduction_db;
         if (!mode_ff) begin
            tgt_in[0] = ENV_W'(mag_new_l) << FB;
            tgt_in[1] = ENV_W'(mag_new_r) << FB;
         end
      end

      case (state_ff)
         sef_pkg::ST_SQ: begin
            if (mul_done) sq_in = mul_prod[MS_W-1:0];
         end
         sef_pkg::ST_MS: begin
            if (mul_done) begin
               ms_in[ch_ff] = ms_up ? (cur_ms + step[MS_W-1:0]) : (cur_ms - step[MS_W-1:0]);
            end
         end
         sef_pkg::ST_ROOT: begin
            if (sqrt_done) tgt_in[ch_ff] = ENV_W'(sqrt_root) << FB;
         end
         sef_pkg::ST_LINK: begin
            if (launch_ff && !ch_ff) peak_in = peak_now;
            if (mul_done) begin
               tgt_in[ch_ff] = cur_tgt + step[ENV_W-1:0];
               // interpolated release, if used, overwrites this after the divide
               if (ch_ff) rel_in = (auto_ff && gr_full) ? fast_c : release_c;
            end
         end
         sef_pkg::ST_REL_MUL: begin
            if (mul_done) begin
               dv_in   = y_sum[sef_pkg::GR_SHIFT +: Y_W];
               rm_in   = '0;
               dcnt_in = '0;
            end
         end
         sef_pkg::ST_REL_DIV: begin
            dv_in   = q_next;
            rm_in   = rm_next;
            dcnt_in = dcnt_ff + DC_W'(1);
            if (div_last) begin
               rel_in = rel_up ? (slow_c + q_next[CW-1:0]) : (slow_c - q_next[CW-1:0]);
            end
         end
         sef_pkg::ST_ENV: begin
            if (mul_done) begin
               env_in[ch_ff] = env_up ? (cur_env + step[ENV_W-1:0])
                                      : (cur_env - step[ENV_W-1:0]);
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         out_in       = env_sat;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            sef_pkg::CSR_DETECTION_MODE:     mode_in    = csr_wdata[0];
            sef_pkg::CSR_AUTO_RELEASE:       auto_in    = csr_wdata[0];
            sef_pkg::CSR_ATTACK_COEFF:       attack_in  = csr_wdata;
            sef_pkg::CSR_RELEASE_COEFF:      release_in = csr_wdata;
            sef_pkg::CSR_RELEASE_FAST_COEFF: fast_in    = csr_wdata;
            sef_pkg::CSR_RELEASE_SLOW_COEFF: slow_in    = csr_wdata;
            sef_pkg::CSR_RMS_COEFF:          rms_in     = csr_wdata;
            sef_pkg::CSR_LINK_AMOUNT:        link_in    = csr_wdata[LW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sef_pkg::ST_IDLE;
         ch_ff        <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         auto_ff      <= 1'b0;
         attack_ff    <= CW'(sef_pkg::ATTACK_RESET);
         release_ff   <= CW'(sef_pkg::RELEASE_RESET);
         fast_ff      <= CW'(sef_pkg::RELEASE_FAST_RESET);
         slow_ff      <= CW'(sef_pkg::RELEASE_SLOW_RESET);
         rms_ff       <= CW'(sef_pkg::RMS_RESET);
         link_ff      <= '0;
         ms_ff[0]     <= '0;
         ms_ff[1]     <= '0;
         env_ff[0]    <= '0;
         env_ff[1]    <= '0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         auto_ff      <= auto_in;
         attack_ff    <= attack_in;
         release_ff   <= release_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         rms_ff       <= rms_in;
         link_ff      <= link_in;
         ms_ff        <= ms_in;
         env_ff       <= env_in;
      end
      mag_ff  <= mag_in;
      gr_ff   <= gr_in;
      sq_ff   <= sq_in;
      tgt_ff  <= tgt_in;
      peak_ff <= peak_in;
      rel_ff  <= rel_in;
      dv_ff   <= dv_in;
      rm_ff   <= rm_in;
      dcnt_ff <= dcnt_in;
      out_ff  <= out_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.envelope_left  = out_ff[0];
   assign rsp_ch.envelope_right = out_ff[1];
endmodule

// ----- hw/rtl/sef_checker.sv -----
// Port-level checks for the stereo envelope follower, bound to the top level.
// Depends on stereo_envelope_follower and its channel interfaces.
module sef_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   logic [1:0] pending_ff, pending_in;

   // words accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without an accepted request");

   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two words in flight");
endmodule

bind stereo_envelope_follower sef_port_checker u_sef_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

// ----- test/sef_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench-side notes: the block's own channel interfaces (sef_req_if, sef_rsp_if) are used
// directly; this file holds the sample word type used by the stimulus.
// Depends on sef_pkg.
package sef_tb_pkg;

   typedef struct packed {
      logic signed [sef_pkg::SAMPLE_BITS-1:0] left;
      logic signed [sef_pkg::SAMPLE_BITS-1:0] right;
      logic [sef_pkg::GR_BITS-1:0]            gr;
   } sample_word_type;

endpackage

// ----- test/sef_checker.sv -----
`timescale 1ns / 100ps
// Envelope predictor and scoreboard for the stereo envelope follower.
// Depends on sef_pkg, sef_req_if and sef_rsp_if; watches the channels and the register port.
module sef_checker (
   input  logic                               clock,
   input  logic                               reset,
   sef_req_if.sink                            req_mon,
   sef_rsp_if.sink                            rsp_mon,
   input  logic                               csr_we,
   input  logic [sef_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sef_pkg::COEFF_BITS:0]       csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);
   localparam int SB = sef_pkg::SAMPLE_BITS;
   localparam int CB = sef_pkg::COEFF_BITS;
   localparam int FB = sef_pkg::ENV_FRAC_BITS;
   localparam logic [63:0] UNITY   = 64'd1 << CB;
   localparam logic [63:0] OUT_MAX = (64'd1 << (SB - 1)) - 1;

   logic        rms_mode, auto_rel;
   logic [24:0] attack_c, release_c, fast_c, slow_c, rms_c;
   logic [16:0] link_c;
   logic [63:0] env_l, env_r, msq_l, msq_r;
   logic [45:0] envelope_q[$];

   function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, int s);
      logic [63:0] lo;
      lo = a & ((64'd1 << s) - 1);
      return (a >> s) * b + ((lo * b + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic logic [63:0] step_toward(logic [63:0] cur, logic [63:0] tgt,
                                               logic [63:0] c, int s);
      if (tgt >= cur) return cur + scale_round(tgt - cur, c, s);
      return cur - scale_round(cur - tgt, c, s);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root, b;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] sat_coeff(logic [63:0] c);
      return c > UNITY ? UNITY : c;
   endfunction

   function automatic logic [63:0] detect_level(logic signed [SB-1:0] x,
                                                ref logic [63:0] msq);
      logic [63:0] mag;
      mag = x < 0 ? 64'(-64'(x)) : 64'(x);
      if (rms_mode) begin
         msq = step_toward(msq, mag * mag, sat_coeff(64'(rms_c)), CB);
         return int_sqrt(msq);
      end
      return mag;
   endfunction

   function automatic logic [22:0] follow(ref logic [63:0] env, logic [63:0] tgt,
                                          logic [63:0] rel);
      logic [63:0] c, o;
      c = tgt > env ? sat_coeff(64'(attack_c)) : rel;
      env = step_toward(env, tgt, c, CB);
      o = env >> FB;
      return 23'(o > OUT_MAX ? OUT_MAX : o);
   endfunction

   function automatic logic [45:0] predict_envelopes(logic signed [SB-1:0] xl,
                                                     logic signed [SB-1:0] xr,
                                                     logic [15:0] gr);
      logic [63:0] tl, tr, pk, lk, rel, sl, fs;
      logic [22:0] ol, orr;
      tl = detect_level(xl, msq_l) << FB;
      tr = detect_level(xr, msq_r) << FB;
      lk = link_c > 17'd65536 ? 64'd65536 : 64'(link_c);
      pk = tl > tr ? tl : tr;
      rel = sat_coeff(64'(release_c));
      tl += scale_round(pk - tl, lk, sef_pkg::LINK_BITS);
      tr += scale_round(pk - tr, lk, sef_pkg::LINK_BITS);
      if (auto_rel) begin
         sl = sat_coeff(64'(slow_c));
         fs = sat_coeff(64'(fast_c));
         if (64'(gr) >= 64'(sef_pkg::GR_FULL)) rel = fs;
         else if (fs >= sl)
            rel = sl + ((fs - sl) * 64'(gr) + 64'(sef_pkg::GR_HALF)) / 64'(sef_pkg::GR_FULL);
         else
            rel = sl - ((sl - fs) * 64'(gr) + 64'(sef_pkg::GR_HALF)) / 64'(sef_pkg::GR_FULL);
      end
      ol = follow(env_l, tl, rel);
      orr = follow(env_r, tr, rel);
      return {ol, orr};
   endfunction

   assign pending = envelope_q.size();

   always @(posedge clock) begin
      logic [45:0] exp_w;
      if (reset) begin
         rms_mode <= 0; auto_rel <= 0;
         attack_c <= 25'(sef_pkg::ATTACK_RESET); release_c <= 25'(sef_pkg::RELEASE_RESET);
         fast_c <= 25'(sef_pkg::RELEASE_FAST_RESET); slow_c <= 25'(sef_pkg::RELEASE_SLOW_RESET);
         rms_c <= 25'(sef_pkg::RMS_RESET); link_c <= 0;
         env_l = 0; env_r = 0; msq_l = 0; msq_r = 0;
         envelope_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               sef_pkg::CSR_DETECTION_MODE:     rms_mode <= csr_wdata[0];
               sef_pkg::CSR_AUTO_RELEASE:       auto_rel <= csr_wdata[0];
               sef_pkg::CSR_ATTACK_COEFF:       attack_c <= csr_wdata;
               sef_pkg::CSR_RELEASE_COEFF:      release_c <= csr_wdata;
               sef_pkg::CSR_RELEASE_FAST_COEFF: fast_c <= csr_wdata;
               sef_pkg::CSR_RELEASE_SLOW_COEFF: slow_c <= csr_wdata;
               sef_pkg::CSR_RMS_COEFF:          rms_c <= csr_wdata;
               sef_pkg::CSR_LINK_AMOUNT:        link_c <= csr_wdata[16:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            envelope_q.push_back(predict_envelopes(req_mon.sample_left,
                  req_mon.sample_right, req_mon.gain_reduction_db));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (envelope_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected envelope word %h %h",
                  rsp_mon.envelope_left, rsp_mon.envelope_right);
            end else begin
               exp_w = envelope_q.pop_front();
               if (rsp_mon.envelope_left !== exp_w[45:23] ||
                   rsp_mon.envelope_right !== exp_w[22:0]) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("envelope mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
                        exp_w[45:23], exp_w[22:0], rsp_mon.envelope_left,
                        rsp_mon.envelope_right);
               end
            end
         end
      end
   end
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Top of the stereo envelope follower testbench: clock, reset, register phases and stimulus.
// Depends on sef_pkg, sef_tb_pkg, the block's interfaces and sef_checker.
module tb;
   localparam int SB    = sef_pkg::SAMPLE_BITS;
   localparam int IB    = sef_pkg::CSR_INDEX_BITS;
   localparam int CSR_W = sef_pkg::COEFF_BITS + 1;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [IB-1:0] csr_index = sef_pkg::CSR_DETECTION_MODE;
   logic [CSR_W-1:0] csr_wdata = 0;
   int fail_count, pending;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_off = 0;
   int unsigned cycle_count = 0;

   sef_req_if req_ch ();
   sef_rsp_if rsp_ch ();

   stereo_envelope_follower uut (.clock(clock), .reset(reset), .req_ch(req_ch),
      .rsp_ch(rsp_ch), .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   sef_checker chk (.clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending));

   always #6 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.sample_left = 0;
      req_ch.sample_right = 0;
      req_ch.gain_reduction_db = 0;
      rsp_ch.ready = 0;
   end

   // receiver: random stalls, or a long hold-off counted here
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3_000_000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [IB-1:0] idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // valid stays high from one word to the next unless the sender idles
   task automatic send_word(sef_tb_pkg::sample_word_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1;
      req_ch.sample_left <= w.left;
      req_ch.sample_right <= w.right;
      req_ch.gain_reduction_db <= w.gr;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [CSR_W-1:0] rand_coeff();
      case ($urandom_range(5))
         0: return 0;
         1: return 25'h1000000;
         2: return 25'h1FFFFFF;
         3: return CSR_W'($urandom_range(25'h1FFFFFF));
         default: return CSR_W'($urandom_range(200000));
      endcase
   endfunction

   function automatic logic signed [SB-1:0] rand_sample();
      case ($urandom_range(7))
         0: return -24'sd8388608;
         1: return 24'sd8388607;
         2: return 0;
         3: return SB'(int'($urandom_range(255)) - 128);
         default: return SB'($urandom);
      endcase
   endfunction

   task automatic random_burst(int n);
      sef_tb_pkg::sample_word_type w;
      for (int i = 0; i < n; i++) begin
         w.left = rand_sample();
         w.right = $urandom_range(3) == 0 ? w.left : rand_sample();
         w.gr = $urandom_range(1) ? 16'($urandom_range(4000)) : 16'($urandom);
         send_word(w);
      end
   endtask

   task automatic random_config();
      csr_write(sef_pkg::CSR_DETECTION_MODE, CSR_W'($urandom_range(1)));
      csr_write(sef_pkg::CSR_AUTO_RELEASE, CSR_W'($urandom_range(1)));
      csr_write(sef_pkg::CSR_ATTACK_COEFF, rand_coeff());
      csr_write(sef_pkg::CSR_RELEASE_COEFF, rand_coeff());
      csr_write(sef_pkg::CSR_RELEASE_FAST_COEFF, rand_coeff());
      csr_write(sef_pkg::CSR_RELEASE_SLOW_COEFF, rand_coeff());
      csr_write(sef_pkg::CSR_RMS_COEFF, rand_coeff());
      case ($urandom_range(3))
         0: csr_write(sef_pkg::CSR_LINK_AMOUNT, 0);
         1: csr_write(sef_pkg::CSR_LINK_AMOUNT, 65536);
         2: csr_write(sef_pkg::CSR_LINK_AMOUNT, 17'h1FFFF);
         default: csr_write(sef_pkg::CSR_LINK_AMOUNT, CSR_W'($urandom_range(65536)));
      endcase
   endtask

   initial begin
      sef_tb_pkg::sample_word_type w;
      repeat (7) @(posedge clock);
      reset <= 0;
      send_idle_pct = 27; recv_idle_pct = 85;

      // directed: reset defaults, field extremes, gain reduction around 12 dB
      w = '{-24'sd8388608, 24'sd8388607, 16'd0}; send_word(w);
      w = '{24'sd8388607, -24'sd8388608, 16'hFFFF}; send_word(w);
      w = '{24'sd0, 24'sd0, 16'd3071}; send_word(w);
      w = '{24'sd1, -24'sd1, 16'd3072}; send_word(w);
      drain();
      csr_write(sef_pkg::CSR_AUTO_RELEASE, 1);
      csr_write(sef_pkg::CSR_RELEASE_FAST_COEFF, 25'h1FFFFFF);
      csr_write(sef_pkg::CSR_RELEASE_SLOW_COEFF, 0);
      csr_write(sef_pkg::CSR_ATTACK_COEFF, 25'h1000000);
      csr_write(sef_pkg::CSR_LINK_AMOUNT, 65536);
      w = '{24'sd8388607, 24'sd100, 16'd1536}; send_word(w);
      w = '{24'sd0, 24'sd0, 16'd1536}; send_word(w);
      w = '{24'sd0, 24'sd0, 16'd5000}; send_word(w);
      drain();
      csr_write(sef_pkg::CSR_DETECTION_MODE, 1);
      csr_write(sef_pkg::CSR_RMS_COEFF, 25'h1FFFFFF);
      csr_write(sef_pkg::CSR_LINK_AMOUNT, 17'h1FFFF);
      csr_write(sef_pkg::CSR_RELEASE_FAST_COEFF, 0);
      csr_write(sef_pkg::CSR_RELEASE_SLOW_COEFF, 25'h1000000);
      w = '{-24'sd8388608, 24'sd3, 16'd1000}; send_word(w);
      w = '{24'sd0, 24'sd0, 16'd2000}; send_word(w);
      drain();
      csr_write(sef_pkg::CSR_RELEASE_COEFF, 0);
      csr_write(sef_pkg::CSR_AUTO_RELEASE, 0);
      csr_write(sef_pkg::CSR_DETECTION_MODE, 0);
      w = '{24'sd5, 24'sd5, 16'd0}; send_word(w);
      w = '{24'sd0, 24'sd0, 16'd0}; send_word(w);
      drain();

      // receiver holds off long while words keep coming
      fork
         begin hold_off = 2000; end
         random_burst(6);
      join
      drain();

      for (int ph = 0; ph < 18; ph++) begin
         if (ph == 6) begin send_idle_pct = 85; recv_idle_pct = 27; end
         if (ph == 12) begin send_idle_pct = 0; recv_idle_pct = 0; end
         random_config();
         random_burst(100);
         drain();
      end

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
